FILE: rtl/afcc_pkg.sv
// ---------------------------------------------------------------------------
// afcc_pkg
// Shared types, constants and the CRC-8 helper for the ASCII frame checker.
// ---------------------------------------------------------------------------
package afcc_pkg;

   // Longest line before it is closed as overlong
   localparam int MAX_LINE = 64;
   localparam int LEN_W    = $clog2(MAX_LINE + 1);

   // Line queue between front and back
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // Character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // CRC-8 Dallas/Maxim, reflected polynomial
   localparam logic [7:0] CRC_POLY = 8'h8C;

   // Frame status codes
   localparam logic [1:0] ST_MATCH    = 2'd0;
   localparam logic [1:0] ST_MISMATCH = 2'd1;
   localparam logic [1:0] ST_MISSING  = 2'd2;

   // Position within the line
   typedef enum logic [5:0] {
      TOK_BEFORE  = 6'b000001,
      TOK_FIRST   = 6'b000010,
      TOK_BETWEEN = 6'b000100,
      TOK_SECOND  = 6'b001000,
      TOK_DONE    = 6'b010000,
      TOK_ENDED   = 6'b100000
   } tok_state_type;

   // Position within one number
   typedef enum logic [2:0] {
      NUM_SKIP   = 3'b001,
      NUM_DIGITS = 3'b010,
      NUM_STOP   = 3'b100
   } num_state_type;

   // One finished line, as sign and magnitude of both fields
   typedef struct packed {
      logic        first_neg;
      logic [31:0] first_mag;
      logic        second_neg;
      logic [31:0] second_mag;
      logic        both;
      logic        over;
   } line_rec_type;

   // CRC contribution of each single value bit, worked out at elaboration
   function automatic logic [31:0][7:0] crc_cols_init();
      logic [31:0][7:0] cols;
      logic [7:0]       crc;
      logic [31:0]      v;
      logic             fb;
      for (int k = 0; k < 32; k++) begin
         crc = 8'h00;
         v   = 32'h1 << k;
         for (int j = 0; j < 32; j++) begin
            fb  = crc[0] ^ v[j];
            crc = crc >> 1;
            if (fb) begin
               crc = crc ^ CRC_POLY;
            end
         end
         cols[k] = crc;
      end
      return cols;
   endfunction

   localparam logic [31:0][7:0] CRC_COLS = crc_cols_init();

   // CRC is linear: XOR together the columns of the set bits
   function automatic logic [7:0] crc8_of(logic [31:0] v);
      logic [7:0] crc;
      crc = 8'h00;
      for (int k = 0; k < 32; k++) begin
         if (v[k]) begin
            crc = crc ^ CRC_COLS[k];
         end
      end
      return crc;
   endfunction

endpackage

FILE: rtl/ascii_frame_crc8_checker_unit.sv
// ---------------------------------------------------------------------------
// ascii_frame_crc8_checker_unit
// Splits received characters into lines, parses the first two '#'-separated
// fields and checks the second against CRC-8 Maxim of the first.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | rx_byte
//  rsp     | out       | rsp_valid/rsp_ready  | encoder_value, computed_crc,
//          |           |                      | frame_status, overlong
//
//  One character is taken every cycle while the line queue has room; the
//  parser updates its state for each character. A line end pushes a record
//  into a two-entry queue; the checker signs, computes the CRC and registers
//  the result.
//  Reset is synchronous and clears all parse and handshake state.
//  req_ready drops only while the line queue is full; a stalled rsp side
//  fills the checker stages, then the queue.
// ---------------------------------------------------------------------------
module ascii_frame_crc8_checker_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_encoder_value,
   output logic [7:0]         rsp_computed_crc,
   output logic [1:0]         rsp_frame_status,
   output logic               rsp_overlong
);

   logic                  q_full, q_push, q_pop, q_not_empty;
   afcc_pkg::line_rec_type push_rec, pop_rec;

   afcc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_rec       (push_rec)
   );

   afcc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_rec  (push_rec),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_rec   (pop_rec)
   );

   afcc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_not_empty       (q_not_empty),
      .q_rec             (pop_rec),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_encoder_value (rsp_encoder_value),
      .rsp_computed_crc  (rsp_computed_crc),
      .rsp_frame_status  (rsp_frame_status),
      .rsp_overlong      (rsp_overlong)
   );

   // Never push a line into a full queue
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("line record pushed into full queue");

   // Reported CRC always belongs to the reported value
   a_crc_consistent : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_computed_crc == afcc_pkg::crc8_of(rsp_encoder_value)))
      else $error("computed_crc does not match encoder_value");

   // A newline accepted with an empty back end shows up as a record next cycle
   a_line_queued : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_rx_byte == afcc_pkg::CH_LF)) |=> q_not_empty)
      else $error("newline did not produce a queued line");

endmodule

FILE: rtl/afcc_front.sv
// ---------------------------------------------------------------------------
// afcc_front
// Per-character line parser: splits fields on '#', parses the first two
// with atoi rules and pushes one line record at each line end.
// ---------------------------------------------------------------------------
module afcc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_rx_byte,
   input  logic                  q_full,
   output logic                  q_push,
   output afcc_pkg::line_rec_type q_rec
);

   logic [afcc_pkg::LEN_W-1:0] len_ff, len_in;
   afcc_pkg::tok_state_type    tok_ff, tok_in, tok_c, tok_b;
   afcc_pkg::num_state_type    num_ff, num_in, num_c;
   logic                       neg_ff, neg_in, neg_c, neg_b;
   logic [31:0]                acc_ff, acc_in, acc_c, acc_b;
   logic                       fneg_ff, fneg_in, fneg_c, fneg_b;
   logic [31:0]                fmag_ff, fmag_in, fmag_c, fmag_b;

   logic       is_ws, is_digit, is_sign, is_hash, is_nul, is_nl;
   logic       live, take, line_end;
   logic [7:0] c;

   // Classify the character
   always_comb begin
      c        = req_rx_byte;
      is_ws    = (c == afcc_pkg::CH_SPACE) ||
                 ((c >= afcc_pkg::CH_TAB) && (c <= afcc_pkg::CH_CR));
      is_digit = (c >= afcc_pkg::CH_ZERO) && (c <= afcc_pkg::CH_NINE);
      is_sign  = (c == afcc_pkg::CH_PLUS) || (c == afcc_pkg::CH_MINUS);
      is_hash  = (c == afcc_pkg::CH_HASH);
      is_nul   = (c == afcc_pkg::CH_NUL);
      is_nl    = (c == afcc_pkg::CH_LF);
   end

   // Apply one content character to the parse state
   always_comb begin
      tok_c  = tok_ff;
      num_c  = num_ff;
      neg_c  = neg_ff;
      acc_c  = acc_ff;
      fneg_c = fneg_ff;
      fmag_c = fmag_ff;
      live   = (tok_ff != afcc_pkg::TOK_DONE) && (tok_ff != afcc_pkg::TOK_ENDED);
      if (live) begin
         if (is_nul) begin
            // end of content: close whatever field is open
            if (tok_ff == afcc_pkg::TOK_FIRST) begin
               fneg_c = neg_ff;
               fmag_c = acc_ff;
               tok_c  = afcc_pkg::TOK_ENDED;
            end else if (tok_ff == afcc_pkg::TOK_SECOND) begin
               tok_c = afcc_pkg::TOK_DONE;
            end else begin
               tok_c = afcc_pkg::TOK_ENDED;
            end
         end else if (is_hash) begin
            if (tok_ff == afcc_pkg::TOK_FIRST) begin
               fneg_c = neg_ff;
               fmag_c = acc_ff;
               tok_c  = afcc_pkg::TOK_BETWEEN;
            end else if (tok_ff == afcc_pkg::TOK_SECOND) begin
               tok_c = afcc_pkg::TOK_DONE;
            end
         end else begin
            // open a new field on its first character
            if (tok_ff == afcc_pkg::TOK_BEFORE || tok_ff == afcc_pkg::TOK_BETWEEN) begin
               num_c = afcc_pkg::NUM_SKIP;
               neg_c = 1'b0;
               acc_c = 32'h0;
               tok_c = (tok_ff == afcc_pkg::TOK_BEFORE) ? afcc_pkg::TOK_FIRST
                                                        : afcc_pkg::TOK_SECOND;
            end
            if (num_c == afcc_pkg::NUM_SKIP && is_ws) begin
               // leading whitespace: hold
            end else if (num_c == afcc_pkg::NUM_SKIP && is_sign) begin
               neg_c = (c == afcc_pkg::CH_MINUS);
               num_c = afcc_pkg::NUM_DIGITS;
            end else if (num_c != afcc_pkg::NUM_STOP && is_digit) begin
               acc_c = (acc_c << 3) + (acc_c << 1) + {28'h0, c[3:0]};
               num_c = afcc_pkg::NUM_DIGITS;
            end else begin
               num_c = afcc_pkg::NUM_STOP;
            end
         end
      end
   end

   // Build the line record from the state the line closes on
   always_comb begin
      line_end = is_nl || (len_ff == afcc_pkg::LEN_W'(afcc_pkg::MAX_LINE));
      tok_b    = is_nl ? tok_ff  : tok_c;
      neg_b    = is_nl ? neg_ff  : neg_c;
      acc_b    = is_nl ? acc_ff  : acc_c;
      fneg_b   = is_nl ? fneg_ff : fneg_c;
      fmag_b   = is_nl ? fmag_ff : fmag_c;
      q_rec.first_neg  = (tok_b == afcc_pkg::TOK_FIRST) ? neg_b : fneg_b;
      q_rec.first_mag  = (tok_b == afcc_pkg::TOK_FIRST) ? acc_b : fmag_b;
      q_rec.second_neg = neg_b;
      q_rec.second_mag = acc_b;
      q_rec.both       = (tok_b == afcc_pkg::TOK_SECOND) || (tok_b == afcc_pkg::TOK_DONE);
      q_rec.over       = !is_nl;
   end

   assign req_ready = !q_full;
   assign take      = req_valid && req_ready;
   assign q_push    = take && line_end;

   // Advance or restart the line
   always_comb begin
      len_in  = len_ff;
      tok_in  = tok_ff;
      num_in  = num_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      fneg_in = fneg_ff;
      fmag_in = fmag_ff;
      if (take) begin
         if (line_end) begin
            len_in  = '0;
            tok_in  = afcc_pkg::TOK_BEFORE;
            num_in  = afcc_pkg::NUM_SKIP;
            neg_in  = 1'b0;
            acc_in  = 32'h0;
            fneg_in = 1'b0;
            fmag_in = 32'h0;
         end else begin
            len_in  = len_ff + 1'b1;
            tok_in  = tok_c;
            num_in  = num_c;
            neg_in  = neg_c;
            acc_in  = acc_c;
            fneg_in = fneg_c;
            fmag_in = fmag_c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         tok_ff  <= afcc_pkg::TOK_BEFORE;
         num_ff  <= afcc_pkg::NUM_SKIP;
         neg_ff  <= 1'b0;
         acc_ff  <= 32'h0;
         fneg_ff <= 1'b0;
         fmag_ff <= 32'h0;
      end else begin
         len_ff  <= len_in;
         tok_ff  <= tok_in;
         num_ff  <= num_in;
         neg_ff  <= neg_in;
         acc_ff  <= acc_in;
         fneg_ff <= fneg_in;
         fmag_ff <= fmag_in;
      end
   end

endmodule

FILE: rtl/afcc_queue.sv
// ---------------------------------------------------------------------------
// afcc_queue
// Short FIFO of finished line records between the parser and the checker.
// ---------------------------------------------------------------------------
module afcc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  afcc_pkg::line_rec_type push_rec,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output afcc_pkg::line_rec_type pop_rec
);

   afcc_pkg::line_rec_type              mem_ff [afcc_pkg::QDEPTH];
   logic [afcc_pkg::QPTR_W-1:0]         wr_ff, wr_in, rd_ff, rd_in;
   logic [afcc_pkg::QCNT_W-1:0]         cnt_ff, cnt_in;
   logic                                do_push, do_pop;

   assign full      = (cnt_ff == afcc_pkg::QCNT_W'(afcc_pkg::QDEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_rec   = mem_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Move pointers and fill count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == afcc_pkg::QPTR_W'(afcc_pkg::QDEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == afcc_pkg::QPTR_W'(afcc_pkg::QDEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the record
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_rec;
      end
   end

endmodule

FILE: rtl/afcc_back.sv
// ---------------------------------------------------------------------------
// afcc_back
// Line checker: signs the field values, computes CRC-8 Maxim of the first
// and compares it with the second, through a two-stage pipeline.
// ---------------------------------------------------------------------------
module afcc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_not_empty,
   input  afcc_pkg::line_rec_type q_rec,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [31:0]    rsp_encoder_value,
   output logic [7:0]            rsp_computed_crc,
   output logic [1:0]            rsp_frame_status,
   output logic                  rsp_overlong
);

   logic        s1_v_ff, s1_v_in;
   logic [31:0] s1_first_ff, s1_second_ff;
   logic        s1_both_ff, s1_over_ff;
   logic        out_v_ff, out_v_in;
   logic [31:0] out_value_ff;
   logic [7:0]  out_crc_ff, crc;
   logic [1:0]  out_status_ff, status;
   logic        out_over_ff;
   logic        out_free, s1_move, s1_free;

   assign out_free = !out_v_ff || rsp_ready;
   assign s1_move  = s1_v_ff && out_free;
   assign s1_free  = !s1_v_ff || out_free;
   assign q_pop    = q_not_empty && s1_free;

   always_comb begin
      s1_v_in  = q_pop ? 1'b1 : (s1_move ? 1'b0 : s1_v_ff);
      out_v_in = s1_move ? 1'b1 : ((out_v_ff && rsp_ready) ? 1'b0 : out_v_ff);
   end

   // Compute the CRC and compare with the second field
   always_comb begin
      crc = afcc_pkg::crc8_of(s1_first_ff);
      if (!s1_both_ff) begin
         status = afcc_pkg::ST_MISSING;
      end else if (s1_second_ff == {24'h0, crc}) begin
         status = afcc_pkg::ST_MATCH;
      end else begin
         status = afcc_pkg::ST_MISMATCH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // Stage one: apply the signs
   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_first_ff  <= q_rec.first_neg ? (32'h0 - q_rec.first_mag) : q_rec.first_mag;
         s1_second_ff <= q_rec.second_neg ? (32'h0 - q_rec.second_mag) : q_rec.second_mag;
         s1_both_ff   <= q_rec.both;
         s1_over_ff   <= q_rec.over;
      end
   end

   // Stage two: hold the result until taken
   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_value_ff  <= s1_first_ff;
         out_crc_ff    <= crc;
         out_status_ff <= status;
         out_over_ff   <= s1_over_ff;
      end
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_encoder_value = out_value_ff;
   assign rsp_computed_crc  = out_crc_ff;
   assign rsp_frame_status  = out_status_ff;
   assign rsp_overlong      = out_over_ff;

endmodule

FILE: verif/ascii_frame_crc8_checker_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ascii_frame_crc8_checker_unit_tb
// Sends serial text lines to the frame checker and checks every line result
// against a built-in line parser and CRC-8 Maxim calculator. Directed tests
// cover the parsing rules and line-end cases, then random lines follow with
// idle bursts on both channels. A final stretch runs with no idling.
// ---------------------------------------------------------------------------
module ascii_frame_crc8_checker_unit_tb;

   localparam int         STALL_LIMIT = 4000;
   localparam logic [7:0] CH_VT       = 8'h0B;
   localparam logic [7:0] CH_FF       = 8'h0C;
   localparam logic [7:0] CH_X        = 8'h78;
   localparam logic [7:0] WS_CHARS [5] = '{afcc_pkg::CH_SPACE, afcc_pkg::CH_TAB, CH_VT,
                                           CH_FF, afcc_pkg::CH_CR};

   // One line result as the block should report it
   typedef struct {
      logic signed [31:0] value;
      logic [7:0]         crc;
      logic [1:0]         status;
      logic               over;
   } line_result_type;

   logic               clock;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_ready   = 1'b0;
   logic signed [31:0] rsp_encoder_value;
   logic [7:0]         rsp_computed_crc;
   logic [1:0]         rsp_frame_status;
   logic               rsp_overlong;

   // Parser state of the line being received
   afcc_pkg::tok_state_type tok       = afcc_pkg::TOK_BEFORE;
   afcc_pkg::num_state_type num       = afcc_pkg::NUM_SKIP;
   logic                    neg       = 1'b0;
   logic [31:0]             acc       = '0;
   logic [31:0]             first_val = '0;
   int unsigned             line_len  = 0;

   line_result_type line_results [$];
   logic [7:0]      frame_buf [$];
   logic            idle_on     = 1'b1;
   int              fail_count  = 0;
   int              chars_sent  = 0;
   int              lines_seen  = 0;
   int              status_seen [3] = '{0, 0, 0};
   int              over_seen   = 0;
   int              rsp_stall   = 0;
   int              quiet_count = 0;

   ascii_frame_crc8_checker_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_encoder_value (rsp_encoder_value),
      .rsp_computed_crc  (rsp_computed_crc),
      .rsp_frame_status  (rsp_frame_status),
      .rsp_overlong      (rsp_overlong)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Line parser and CRC
   // ------------------------------------------------------------------------

   // Bit-serial CRC-8 Maxim, value bytes low first
   function automatic logic [7:0] maxim_crc8(logic [31:0] v);
      logic [7:0] crc;
      logic       fb;
      int         k;
      crc = 8'h00;
      for (k = 0; k < 32; k++) begin
         fb  = crc[0] ^ v[k];
         crc = crc >> 1;
         if (fb) begin
            crc = crc ^ afcc_pkg::CRC_POLY;
         end
      end
      return crc;
   endfunction

   function automatic void begin_field();
      num = afcc_pkg::NUM_SKIP;
      neg = 1'b0;
      acc = '0;
   endfunction

   function automatic logic [31:0] signed_field();
      return neg ? (32'd0 - acc) : acc;
   endfunction

   // Close the content part of the line (zero byte or line end)
   function automatic void end_content();
      if (tok == afcc_pkg::TOK_FIRST) begin
         first_val = signed_field();
         tok       = afcc_pkg::TOK_ENDED;
      end else if (tok == afcc_pkg::TOK_BEFORE || tok == afcc_pkg::TOK_BETWEEN) begin
         tok = afcc_pkg::TOK_ENDED;
      end else if (tok == afcc_pkg::TOK_SECOND) begin
         acc = signed_field();
         tok = afcc_pkg::TOK_DONE;
      end
   endfunction

   function automatic void content_char(logic [7:0] c);
      logic ws;
      logic digit;
      ws    = (c == afcc_pkg::CH_SPACE) || (c >= afcc_pkg::CH_TAB && c <= afcc_pkg::CH_CR);
      digit = (c >= afcc_pkg::CH_ZERO && c <= afcc_pkg::CH_NINE);
      if (tok == afcc_pkg::TOK_DONE || tok == afcc_pkg::TOK_ENDED) return;
      if (c == afcc_pkg::CH_NUL) begin
         end_content();
         return;
      end
      // a run of hashes closes the field in progress
      if (c == afcc_pkg::CH_HASH) begin
         if (tok == afcc_pkg::TOK_FIRST) begin
            first_val = signed_field();
            tok       = afcc_pkg::TOK_BETWEEN;
         end else if (tok == afcc_pkg::TOK_SECOND) begin
            acc = signed_field();
            tok = afcc_pkg::TOK_DONE;
         end
         return;
      end
      if (tok == afcc_pkg::TOK_BEFORE) begin
         begin_field();
         tok = afcc_pkg::TOK_FIRST;
      end else if (tok == afcc_pkg::TOK_BETWEEN) begin
         begin_field();
         tok = afcc_pkg::TOK_SECOND;
      end
      // atoi rules: whitespace, one sign, digits, stop at anything else
      if (num == afcc_pkg::NUM_SKIP && ws) return;
      if (num == afcc_pkg::NUM_SKIP &&
          (c == afcc_pkg::CH_PLUS || c == afcc_pkg::CH_MINUS)) begin
         neg = (c == afcc_pkg::CH_MINUS);
         num = afcc_pkg::NUM_DIGITS;
         return;
      end
      if (num != afcc_pkg::NUM_STOP && digit) begin
         acc = acc * 32'd10 + {24'd0, c - afcc_pkg::CH_ZERO};
         num = afcc_pkg::NUM_DIGITS;
         return;
      end
      num = afcc_pkg::NUM_STOP;
   endfunction

   // Finish the line, queue its expected result and start afresh
   function automatic void close_line(logic over);
      line_result_type r;
      end_content();
      r.value = first_val;
      r.crc   = maxim_crc8(first_val);
      r.over  = over;
      if (tok == afcc_pkg::TOK_DONE) begin
         r.status = (acc == {24'd0, r.crc}) ? afcc_pkg::ST_MATCH : afcc_pkg::ST_MISMATCH;
      end else begin
         r.status = afcc_pkg::ST_MISSING;
      end
      line_results.push_back(r);
      status_seen[r.status]++;
      if (over) over_seen++;
      tok       = afcc_pkg::TOK_BEFORE;
      first_val = '0;
      line_len  = 0;
      begin_field();
   endfunction

   function automatic void predict_char(logic [7:0] c);
      if (c == afcc_pkg::CH_LF) begin
         close_line(1'b0);
         return;
      end
      content_char(c);
      line_len++;
      if (line_len > afcc_pkg::MAX_LINE) close_line(1'b1);
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Send one character; may open with an idle burst
   task automatic send_char(input logic [7:0] c);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= c;
      do @(posedge clock); while (!req_ready);
      chars_sent++;
      predict_char(c);
   endtask

   task automatic send_frame();
      int i;
      for (i = 0; i < frame_buf.size(); i++) send_char(frame_buf[i]);
      frame_buf.delete();
   endtask

   function automatic void add_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
   endfunction

   // Append a random first-field number and return its wrapped value
   function automatic void add_value(output logic [31:0] v);
      int d;
      int n;
      logic minus;
      case ($urandom_range(0, 3))
         0: begin
            v = $urandom_range(0, 999);
            add_text($sformatf("%0d", v));
         end
         1: begin
            v = $urandom;
            add_text($sformatf("%0d", $signed(v)));
         end
         2: begin
            // unsigned text above the signed range wraps
            v = $urandom;
            if ($urandom_range(0, 1)) frame_buf.push_back(afcc_pkg::CH_PLUS);
            add_text($sformatf("%0d", v));
         end
         default: begin
            minus = $urandom_range(0, 1);
            if (minus) frame_buf.push_back(afcc_pkg::CH_MINUS);
            v = '0;
            n = $urandom_range(10, 13);
            repeat (n) begin
               d = $urandom_range(0, 9);
               frame_buf.push_back(8'(afcc_pkg::CH_ZERO + d));
               v = v * 32'd10 + d;
            end
            if (minus) v = 32'd0 - v;
         end
      endcase
   endfunction

   // Well-formed content, no line end
   function automatic void add_good_content();
      logic [31:0] v;
      logic [7:0]  crc;
      int          k;
      repeat ($urandom_range(0, 2)) frame_buf.push_back(WS_CHARS[$urandom_range(0, 4)]);
      add_value(v);
      crc = maxim_crc8(v);
      if ($urandom_range(0, 7) == 0) frame_buf.push_back(CH_X);
      repeat ($urandom_range(1, 3)) frame_buf.push_back(afcc_pkg::CH_HASH);
      repeat ($urandom_range(0, 1)) frame_buf.push_back(WS_CHARS[$urandom_range(0, 4)]);
      k = $urandom_range(0, 9);
      if (k < 6)       add_text($sformatf("%0d", crc));
      else if (k == 6) add_text($sformatf("+%0d", crc));
      else if (k == 7) add_text($sformatf("%0d", crc + 256));
      else if (k == 8) add_text($sformatf("-%0d", crc));
      else             add_text($sformatf("%0d", $urandom_range(0, 255)));
      case ($urandom_range(0, 3))
         0: add_text("#77#x");
         1: add_text("zz");
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Result side: random stall bursts, then check each result
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         rsp_stall = $urandom_range(0, 16);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      line_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         lines_seen++;
         if (line_results.size() == 0) begin
            $error("result with no line pending: value %0d", rsp_encoder_value);
            fail_count++;
         end else begin
            e = line_results.pop_front();
            if (rsp_encoder_value !== e.value) begin
               $error("encoder_value: expected %0d, got %0d", e.value, rsp_encoder_value);
               fail_count++;
            end
            if (rsp_computed_crc !== e.crc) begin
               $error("computed_crc: expected %0d, got %0d", e.crc, rsp_computed_crc);
               fail_count++;
            end
            if (rsp_frame_status !== e.status) begin
               $error("frame_status: expected %0d, got %0d", e.status, rsp_frame_status);
               fail_count++;
            end
            if (rsp_overlong !== e.over) begin
               $error("overlong: expected %0d, got %0d", e.over, rsp_overlong);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_count = 0;
      end else begin
         quiet_count++;
      end
      if (quiet_count >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Correct and wrong CRCs, value extremes and 32-bit wrap
   task automatic test_matching_frames();
      add_text($sformatf("0#%0d\n", maxim_crc8(32'd0)));
      add_text($sformatf("2147483647#%0d\n", maxim_crc8(32'h7FFF_FFFF)));
      add_text($sformatf("-2147483648#%0d\n", maxim_crc8(32'h8000_0000)));
      add_text($sformatf("4294967295#%0d\n", maxim_crc8(32'hFFFF_FFFF)));
      add_text("5#0\n");
      send_frame();
   endtask

   // Whitespace, signs, stop characters and fields past the second
   task automatic test_number_rules();
      add_text(" \t+12abc##  -7x#9\n");
      frame_buf.push_back(CH_VT);
      frame_buf.push_back(CH_FF);
      frame_buf.push_back(afcc_pkg::CH_CR);
      add_text("-#\n");
      add_text("+-5#0\n");
      add_text($sformatf("12 34#%0d#junk#1\n", maxim_crc8(32'd12)));
      frame_buf.push_back(8'hFF);
      frame_buf.push_back(8'h80);
      add_text("#0\n");
      send_frame();
   endtask

   // Empty line, hashes only, one field, dangling separator
   task automatic test_missing_fields();
      add_text("\n###\n123\n123#\n#5\n");
      send_frame();
   endtask

   // A zero byte ends the content; the rest of the line is only counted
   task automatic test_zero_byte();
      add_text("7");
      frame_buf.push_back(afcc_pkg::CH_NUL);
      add_text("#0\n");
      add_text($sformatf("7#%0d", maxim_crc8(32'd7)));
      frame_buf.push_back(afcc_pkg::CH_NUL);
      add_text("junk#1\n7#");
      frame_buf.push_back(afcc_pkg::CH_NUL);
      add_text("5\n");
      send_frame();
   endtask

   // Close by length; the last character is still content
   task automatic test_overlong_lines();
      repeat (afcc_pkg::MAX_LINE + 1) frame_buf.push_back(afcc_pkg::CH_ZERO + 8'd1);
      repeat (afcc_pkg::MAX_LINE) frame_buf.push_back(CH_X);
      frame_buf.push_back(afcc_pkg::CH_LF);
      add_text("3#");
      repeat (afcc_pkg::MAX_LINE - 2) frame_buf.push_back(afcc_pkg::CH_SPACE);
      frame_buf.push_back(afcc_pkg::CH_LF);
      send_frame();
   endtask

   // Mostly well-formed lines with random content, plus broken lines and noise
   task automatic test_random_lines(input int n_chars);
      int          start;
      int          kind;
      int          n;
      logic [31:0] v;
      logic [7:0]  b;
      start = chars_sent;
      while (chars_sent - start < n_chars) begin
         kind = $urandom_range(0, 19);
         if (kind < 12) begin
            add_good_content();
            frame_buf.push_back(afcc_pkg::CH_LF);
         end else if (kind < 14) begin
            case ($urandom_range(0, 3))
               0: ;
               1: add_text("##");
               2: add_value(v);
               default: begin
                  add_value(v);
                  add_text("# ");
               end
            endcase
            frame_buf.push_back(afcc_pkg::CH_LF);
         end else if (kind < 16) begin
            add_good_content();
            frame_buf.insert($urandom_range(0, frame_buf.size()), afcc_pkg::CH_NUL);
            frame_buf.push_back(afcc_pkg::CH_LF);
         end else if (kind == 16) begin
            n = $urandom_range(afcc_pkg::MAX_LINE + 1, afcc_pkg::MAX_LINE + 8);
            repeat (n) begin
               case ($urandom_range(0, 3))
                  0: b = 8'(afcc_pkg::CH_ZERO + $urandom_range(0, 9));
                  1: b = afcc_pkg::CH_HASH;
                  2: b = afcc_pkg::CH_SPACE;
                  default: begin
                     b = 8'($urandom_range(0, 255));
                     if (b == afcc_pkg::CH_LF) b = afcc_pkg::CH_HASH;
                  end
               endcase
               frame_buf.push_back(b);
            end
            if ($urandom_range(0, 1)) frame_buf.push_back(afcc_pkg::CH_LF);
         end else begin
            repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom_range(0, 255)));
         end
         send_frame();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_matching_frames();
      test_number_rules();
      test_missing_fields();
      test_zero_byte();
      test_overlong_lines();
      test_random_lines(1000);
      // last stretch: both sides run flat out
      idle_on = 1'b0;
      test_random_lines(200);
      req_valid <= 1'b0;

      // drain the outstanding lines, then allow for the checker pipeline
      while (line_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d characters sent, %0d line results checked", chars_sent, lines_seen);
      $display("lines: %0d crc match, %0d crc mismatch, %0d field missing, %0d overlong",
               status_seen[afcc_pkg::ST_MATCH], status_seen[afcc_pkg::ST_MISMATCH],
               status_seen[afcc_pkg::ST_MISSING], over_seen);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
